// ===== rtl/core/dle_dfrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_dfrm_pkg
// Shared constants and types for the DLE/STX/ETX deframer.
// ----------------------------------------------------------------------------
package dle_dfrm_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int COUNT_LIMIT = 4096;
    localparam int COUNT_W     = $clog2(COUNT_LIMIT);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 12;
    localparam int KIND_W = 2;

    localparam logic [BYTE_W-1:0] SYM_DLE = 8'h10;
    localparam logic [BYTE_W-1:0] SYM_STX = 8'h02;
    localparam logic [BYTE_W-1:0] SYM_ETX = 8'h03;

    typedef enum logic [KIND_W-1:0] {
        EV_PAYLOAD = 2'd0,
        EV_START   = 2'd1,
        EV_GOOD    = 2'd2,
        EV_BAD     = 2'd3
    } event_kind_t;

    typedef struct packed {
        event_kind_t       event_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  frame_length;
    } result_t;

endpackage

// ===== rtl/core/dle_dfrm_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_dfrm_in_stage
// Input register: holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module dle_dfrm_in_stage
    import dle_dfrm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              take_ok,
    output logic              in_valid,
    output logic [BYTE_W-1:0] in_byte
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // held byte leaves whenever downstream can take it
    assign s_tready = !valid_reg || take_ok;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take_ok) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== rtl/core/dle_dfrm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_dfrm_core
// Framing state and decode: escape flag, frame flag and payload count.
// ----------------------------------------------------------------------------
module dle_dfrm_core
    import dle_dfrm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              framing_enable,
    input  logic              take,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_valid,
    output result_t           res
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(COUNT_LIMIT - 1);

    logic               after_escape_reg, after_escape_next;
    logic               in_frame_reg, in_frame_next;
    logic [COUNT_W-1:0] payload_count_reg, payload_count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               len_ok;

    assign count_inc = (payload_count_reg == COUNT_MAX) ? '0
                                                        : payload_count_reg + COUNT_W'(1);
    assign len_ok    = (payload_count_reg % COUNT_W'(BLOCK_BYTES)) == '0;

    always_comb begin
        after_escape_next  = after_escape_reg;
        in_frame_next      = in_frame_reg;
        payload_count_next = payload_count_reg;
        res_valid          = 1'b0;
        res                = '0;
        if (take && framing_enable) begin
            if (!after_escape_reg) begin
                if (rx_byte == SYM_DLE) begin
                    after_escape_next = 1'b1;
                end else if (in_frame_reg) begin
                    payload_count_next = count_inc;
                    res_valid          = 1'b1;
                    res.event_kind     = EV_PAYLOAD;
                    res.payload_byte   = rx_byte;
                    res.frame_length   = LEN_W'(count_inc);
                end
            end else begin
                after_escape_next = 1'b0;
                priority if (rx_byte == SYM_STX) begin
                    in_frame_next      = 1'b1;
                    payload_count_next = '0;
                    res_valid          = 1'b1;
                    res.event_kind     = EV_START;
                end else if (rx_byte == SYM_ETX) begin
                    if (in_frame_reg) begin
                        in_frame_next      = 1'b0;
                        payload_count_next = '0;
                        res_valid          = 1'b1;
                        res.event_kind     = len_ok ? EV_GOOD : EV_BAD;
                        res.frame_length   = LEN_W'(payload_count_reg);
                    end
                end else if (rx_byte == SYM_DLE) begin
                    // stuffed DLE is data
                    if (in_frame_reg) begin
                        payload_count_next = count_inc;
                        res_valid          = 1'b1;
                        res.event_kind     = EV_PAYLOAD;
                        res.payload_byte   = rx_byte;
                        res.frame_length   = LEN_W'(count_inc);
                    end
                end else begin
                    // unknown escape: dropped, frame state kept
                    res_valid = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_escape_reg  <= 1'b0;
            in_frame_reg      <= 1'b0;
            payload_count_reg <= '0;
        end else begin
            after_escape_reg  <= after_escape_next;
            in_frame_reg      <= in_frame_next;
            payload_count_reg <= payload_count_next;
        end
    end

endmodule

// ===== rtl/core/dle_dfrm_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_dfrm_out_stage
// Result register toward the master side.
// ----------------------------------------------------------------------------
module dle_dfrm_out_stage
    import dle_dfrm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    output logic    free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// ===== rtl/core/dle_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_frame_deframer
// Receive-side DLE/STX/ETX deframer with byte unstuffing.
// ----------------------------------------------------------------------------
// Accepted bytes go through the input register, combinational decode and result register.
// Throughput: one byte per cycle, set by the input and result registers, while the result
// register is free; bytes that produce no event still wait for it but do not load it.
// Reset (aresetn low, synchronous): no escape pending, outside any frame,
// count zero, both stages empty, framing_enable set to 1.
module dle_frame_deframer
    import dle_dfrm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // framing_enable
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    // events
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [7:0] payload_byte, [19:8] frame_length, zero pad
    output logic [1:0]  m_tuser        // [1:0] event_kind
);

    logic              framing_enable_reg;
    logic              take_ok;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              take;
    logic              res_valid;
    result_t           res;
    result_t           m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            framing_enable_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            framing_enable_reg <= cfg_data;
        end
    end

    dle_dfrm_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .take_ok  (take_ok),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    assign take = in_valid && take_ok;

    dle_dfrm_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .framing_enable (framing_enable_reg),
        .take           (take),
        .rx_byte        (in_byte),
        .res_valid      (res_valid),
        .res            (res)
    );

    dle_dfrm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .free     (take_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {4'b0000, m_res.frame_length, m_res.payload_byte};
    assign m_tuser = m_res.event_kind;

endmodule

// ===== rtl/core/dle_dfrm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_dfrm_checker
// Port-level checks on the deframer event stream.
// ----------------------------------------------------------------------------
module dle_dfrm_checker
    import dle_dfrm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("event changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("event valid after reset");

    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_START |-> m_tdata == 24'd0)
        else $error("frame start carries data");

    a_end_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_GOOD || m_tuser == EV_BAD) |-> m_tdata[7:0] == 8'd0)
        else $error("frame end carries a payload byte");

    a_good_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_GOOD |-> (m_tdata[19:8] % LEN_W'(BLOCK_BYTES)) == '0)
        else $error("good frame with partial block");

endmodule

bind dle_frame_deframer dle_dfrm_checker u_dle_dfrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dle_frame_deframer: drives framed and noisy byte
// streams with random gaps and back-pressure, predicts every event in a
// scoreboard and compares each received event field by field.
// ----------------------------------------------------------------------------
module testbench;
    import dle_dfrm_pkg::*;

    // event prediction and checking
    class frame_scoreboard;
        result_t           expected_q[$];
        bit                framing_en;
        bit                escape_pending;
        bit                inside_frame;
        logic [LEN_W-1:0]  byte_count;
        int                errors;
        int                events_checked;
        int                verdicts_checked;

        function new();
            framing_en     = 1'b1;
            escape_pending = 1'b0;
            inside_frame   = 1'b0;
            byte_count     = '0;
        endfunction

        function void set_enable(bit en);
            framing_en = en;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_expect(event_kind_t k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] n);
            result_t r;
            r.event_kind   = k;
            r.payload_byte = d;
            r.frame_length = n;
            expected_q.push_back(r);
        endfunction

        function void take_payload(logic [BYTE_W-1:0] d);
            if (!inside_frame)
                return;
            byte_count = LEN_W'((int'(byte_count) + 1) % COUNT_LIMIT);
            add_expect(EV_PAYLOAD, d, byte_count);
        endfunction

        // called for every transaction accepted on the byte input
        function void note_byte(logic [BYTE_W-1:0] rx);
            if (!framing_en)
                return;
            if (!escape_pending) begin
                if (rx == SYM_DLE)
                    escape_pending = 1'b1;
                else
                    take_payload(rx);
                return;
            end
            escape_pending = 1'b0;
            if (rx == SYM_STX) begin
                inside_frame = 1'b1;
                byte_count   = '0;
                add_expect(EV_START, '0, '0);
            end else if (rx == SYM_ETX) begin
                if (inside_frame) begin
                    if (int'(byte_count) % BLOCK_BYTES == 0)
                        add_expect(EV_GOOD, '0, byte_count);
                    else
                        add_expect(EV_BAD, '0, byte_count);
                    inside_frame = 1'b0;
                    byte_count   = '0;
                end
            end else if (rx == SYM_DLE) begin
                take_payload(rx);
            end
            // any other escaped byte is dropped
        endfunction

        function void check_event(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d,
                                  logic [LEN_W-1:0] n);
            result_t exp_r;
            events_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("testbench: unexpected event kind %0d byte %02h len %0d",
                             k, d, n);
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.event_kind != EV_PAYLOAD)
                verdicts_checked++;
            if (exp_r.event_kind !== k || exp_r.payload_byte !== d
                || exp_r.frame_length !== n) begin
                errors++;
                if (errors <= 10)
                    $display("testbench: mismatch exp kind/byte/len %0d/%02h/%0d, got %0d/%02h/%0d",
                             exp_r.event_kind, exp_r.payload_byte, exp_r.frame_length,
                             k, d, n);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [7:0] payload_byte, [19:8] frame_length, zero pad
    logic [1:0]  m_tuser;            // [1:0] event_kind

    frame_scoreboard sb = new();
    int bytes_sent = 0;
    int src_rush   = 0;
    int sink_rush  = 0;

    logic [7:0] opening_seq[$] = '{
        8'h00, 8'hFF, SYM_DLE, SYM_ETX, SYM_DLE, SYM_DLE,          // outside any frame
        SYM_DLE, SYM_STX, 8'h00, 8'hFF, SYM_STX, SYM_ETX,          // start, plain payload
        SYM_DLE, SYM_DLE, SYM_DLE, 8'h55, 8'hAA,                   // stuffed DLE, bad escape
        SYM_DLE, SYM_ETX,                                          // bad length
        SYM_DLE, SYM_STX, SYM_DLE, SYM_STX, SYM_DLE, SYM_ETX       // restart, empty good
    };

    dle_frame_deframer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        if (src_rush > 0) begin
            gap = 0;
            src_rush--;
        end else begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 29) == 0)
                src_rush = $urandom_range(10, 80);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(rx);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_payload(input logic [7:0] rx);
        if (rx == SYM_DLE)
            send_byte(SYM_DLE);
        send_byte(rx);
    endtask

    // pause the input until every predicted event has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cfg(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_enable(en);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_frame();
        int n_noise;
        int n_payload;
        int pick;
        logic [7:0] rx;
        n_noise = $urandom_range(0, 3);
        repeat (n_noise) send_byte(8'($urandom_range(0, 255)));
        send_byte(SYM_DLE);
        send_byte(SYM_STX);
        if ($urandom_range(0, 1) == 0)
            n_payload = BLOCK_BYTES * $urandom_range(0, 3);
        else
            n_payload = $urandom_range(1, 40);
        repeat (n_payload) begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                rx = SYM_DLE;
            else if (pick == 3)
                rx = SYM_STX;
            else if (pick == 4)
                rx = SYM_ETX;
            else
                rx = 8'($urandom_range(0, 255));
            send_payload(rx);
            if ($urandom_range(0, 24) == 0) begin
                // unknown escape sequence, dropped by the block
                do rx = 8'($urandom_range(0, 255));
                while (rx == SYM_DLE || rx == SYM_STX || rx == SYM_ETX);
                send_byte(SYM_DLE);
                send_byte(rx);
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            send_byte(SYM_DLE);
            send_byte(SYM_ETX);
        end else if (pick == 8) begin
            send_byte(SYM_ETX);    // unescaped ETX: just payload
        end
        // else the frame is abandoned and the next start restarts it
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            send_random_frame();
            if ($urandom_range(0, 15) == 0)
                wait_idle();
        end
    endtask

    // result side: random stalls with stretches of continuous ready
    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (sink_rush > 0) begin
                stall = 0;
                sink_rush--;
            end else begin
                stall = $urandom_range(0, 9);
                if ($urandom_range(0, 19) == 0)
                    sink_rush = $urandom_range(10, 60);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_event(m_tuser, m_tdata[7:0], m_tdata[19:8]);
            @(negedge aclk);
        end
    end

    initial begin
        #1500000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening_seq[i]) send_byte(opening_seq[i]);
        run_random(700);

        // framing off: everything ignored, state held
        wait_idle();
        write_cfg(1'b0);
        run_random(200);
        wait_idle();
        write_cfg(1'b1);

        wait_idle();
        write_cfg(1'b1);
        run_random(950);

        wait_idle();
        $display("testbench: %0d bytes driven, %0d events checked, %0d of them starts/verdicts",
                 bytes_sent, sb.events_checked, sb.verdicts_checked);
        $display("testbench: corner opening, random frames under stalls, framing off and on");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: %0d failures", sb.errors + sb.pending());
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dle_dfrm_pkg.sv
rtl/core/dle_dfrm_in_stage.sv
rtl/core/dle_dfrm_core.sv
rtl/core/dle_dfrm_out_stage.sv
rtl/core/dle_frame_deframer.sv
rtl/core/dle_dfrm_checker.sv
bench/testbench.sv
